// ===== design/lsuk_pkg.sv =====
// Shared types and constants for the unique-key LIFO stack.
package lsuk_pkg;

  // Default number of stack entries
  localparam int DEPTH_DEF = 16;

  // Width of one key or data word
  localparam int WORD_W = 32;

  // Request kind carried on the input tuser
  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  // Result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

endpackage

// ===== design/lsuk_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module lsuk_ram #(
  parameter int DEPTH = lsuk_pkg::DEPTH_DEF,
  parameter int W = 2 * lsuk_pkg::WORD_W,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read: the data appears the cycle after the address
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/lifo_stack_unique_keys.sv =====
// Unique-key LIFO stack of key and data pairs: control sequencer and result register.
// Each request gives exactly one result. A push walks the stored keys through the
// stack RAM's single read port, one key per cycle. The walk stops early on a matching
// key; a walk that reaches the end compares the top key in its last step and writes
// the new pair if that key differs and room remains. The result register is loaded
// after the walk, and the next request is taken once the result is loaded. A pop that
// underflows or empties the stack needs no RAM read, and a pop that leaves entries
// reads the new top back from the RAM. A result that the receiver holds off delays
// the result register load and with it the next request. The top
// pair is held in registers, so no clearing pass is needed after reset. A finished
// result waits in the output register while the next request is accepted. Status on
// m_tuser: ok, duplicate key, underflow, overflow.
module lifo_stack_unique_keys #(
  parameter int DEPTH = lsuk_pkg::DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int OUT_W = ((4 * lsuk_pkg::WORD_W + CW + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // Requests
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,  // in_key [31:0], in_data [63:32]
  input  logic             s_tuser,  // kind
  // Results
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // popped_key, popped_data, top_key, top_data,
                                     // entry_count, is_empty, zero fill
  output logic [1:0]       m_tuser   // status
);

  import lsuk_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PAD_W = OUT_W - (4 * WORD_W + CW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP_RD,
    S_POP_WAIT,
    S_FINISH
  } state_t;

  state_t                state;
  logic [CW-1:0]         fill;
  logic [CW-1:0]         idx;
  logic                  pend;
  logic [WORD_W-1:0]     req_key;
  logic [WORD_W-1:0]     req_data;
  logic [WORD_W-1:0]     top_key;
  logic [WORD_W-1:0]     top_data;
  logic [WORD_W-1:0]     pop_key;
  logic [WORD_W-1:0]     pop_data;
  status_t               st;

  logic                  ram_we;
  logic [AW-1:0]         ram_rd_addr;
  logic [2*WORD_W-1:0]   ram_rd_data;
  logic [CW-1:0]         fill_m1;
  logic                  key_match;
  logic                  scan_done;
  logic                  out_free;
  logic                  in_fire;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign fill_m1  = fill - CW'(1);

  // Compare the key read last cycle; stop when every held key was issued
  assign key_match = pend && (ram_rd_data[WORD_W-1:0] == req_key);
  assign scan_done = (idx == fill);

  // Write the new pair when the walk ends without a match and room remains
  assign ram_we = (state == S_SCAN) && !key_match && scan_done &&
                  (fill != CW'(DEPTH));

  // Walk addresses during a push, else the entry under the top
  always_comb begin
    if (state == S_SCAN) begin
      ram_rd_addr = idx[AW-1:0];
    end else begin
      ram_rd_addr = fill_m1[AW-1:0];
    end
  end

  lsuk_ram #(
    .DEPTH (DEPTH),
    .W     (2 * WORD_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (fill[AW-1:0]),
    .wr_data ({req_data, req_key}),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequence requests, track fill and top, and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      idx      <= '0;
      pend     <= 1'b0;
      top_key  <= '0;
      top_data <= '0;
      st       <= ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      // Drop a taken result unless a new one replaces it
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_key  <= s_tdata[WORD_W-1:0];
            req_data <= s_tdata[2*WORD_W-1:WORD_W];
            idx      <= '0;
            pend     <= 1'b0;
            if (s_tuser == KIND_PUSH) begin
              pop_key  <= '0;
              pop_data <= '0;
              st       <= ST_OK;
              state    <= S_SCAN;
            end else if (fill == '0) begin
              pop_key  <= '0;
              pop_data <= '0;
              st       <= ST_UNDER;
              state    <= S_FINISH;
            end else begin
              pop_key  <= top_key;
              pop_data <= top_data;
              st       <= ST_OK;
              fill     <= fill_m1;
              if (fill == CW'(1)) begin
                top_key  <= '0;
                top_data <= '0;
                state    <= S_FINISH;
              end else begin
                state <= S_POP_RD;
              end
            end
          end
        end
        S_SCAN: begin
          if (key_match) begin
            st    <= ST_DUP;
            pend  <= 1'b0;
            state <= S_FINISH;
          end else if (scan_done) begin
            pend <= 1'b0;
            if (fill == CW'(DEPTH)) begin
              st <= ST_OVER;
            end else begin
              top_key  <= req_key;
              top_data <= req_data;
              fill     <= fill + CW'(1);
            end
            state <= S_FINISH;
          end else begin
            idx  <= idx + CW'(1);
            pend <= 1'b1;
          end
        end
        S_POP_RD: begin
          state <= S_POP_WAIT;
        end
        S_POP_WAIT: begin
          top_key  <= ram_rd_data[WORD_W-1:0];
          top_data <= ram_rd_data[2*WORD_W-1:WORD_W];
          state    <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= st;
            m_tdata  <= {{PAD_W{1'b0}}, (fill == '0), fill,
                         top_data, top_key, pop_data, pop_key};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Fill level never exceeds the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill level above depth");

  // The walk never issues past the held entries
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx <= fill))
    else $error("key walk past fill level");

  // An empty stack shows a zero top pair
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (top_key == '0 && top_data == '0))
    else $error("empty stack with nonzero top");

  // A RAM write only happens below the depth
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (fill < CW'(DEPTH)))
    else $error("write into full stack");

  // A written push raises the fill level by one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (fill == $past(fill) + CW'(1)))
    else $error("push did not advance fill level");

endmodule

// ===== tb/sv/lifo_stack_unique_keys_test.sv =====
// Self-checking testbench for the unique-key LIFO stack: directed and random requests.
module lifo_stack_unique_keys_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lsuk_pkg::*;

  localparam int STACK_DEPTH  = DEPTH_DEF;
  localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int OUT_W        = ((4 * WORD_W + CNT_W + 1 + 7) / 8) * 8;
  localparam int RANDOM_REQS  = 1350;
  localparam int KEY_POOL_N   = 24;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = STACK_DEPTH + 3 + 30;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 100;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] key;
    logic [31:0] data;
  } stack_req_t;

  typedef struct packed {
    status_t          status;
    logic [31:0]      popped_key;
    logic [31:0]      popped_data;
    logic [31:0]      top_key;
    logic [31:0]      top_data;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
  } stack_res_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [63:0]      s_tdata = '0;  // in_key [31:0], in_data [63:32]
  logic             s_tuser = KIND_PUSH;  // kind
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;  // popped_key, popped_data, top_key, top_data,
                              // entry_count, is_empty, zero fill
  logic [1:0]       m_tuser;  // status

  // Requests waiting to be sent and results waiting to arrive
  stack_req_t pending_reqs[$];
  stack_res_t expected_results[$];

  // Shadow copy of the stack contents
  logic [31:0] stk_keys[STACK_DEPTH];
  logic [31:0] stk_data[STACK_DEPTH];
  int          stk_count = 0;

  int error_cnt = 0;
  int accepted_cnt = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int tx_wait = 0;
  int rx_wait = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  lifo_stack_unique_keys uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow stack and return the result it gives
  function automatic stack_res_t apply_stack_request(stack_req_t req);
    stack_res_t res;
    bit         found;
    res = '0;
    res.status = ST_OK;
    found = 1'b0;
    if (req.kind == KIND_PUSH) begin
      for (int i = 0; i < stk_count; i++)
        if (stk_keys[i] == req.key) found = 1'b1;
      // key match wins over a full stack
      if (found) begin
        res.status = ST_DUP;
      end else if (stk_count >= STACK_DEPTH) begin
        res.status = ST_OVER;
      end else begin
        stk_keys[stk_count] = req.key;
        stk_data[stk_count] = req.data;
        stk_count++;
      end
    end else begin
      if (stk_count == 0) begin
        res.status = ST_UNDER;
      end else begin
        stk_count--;
        res.popped_key  = stk_keys[stk_count];
        res.popped_data = stk_data[stk_count];
      end
    end
    // peek at the new top
    if (stk_count > 0) begin
      res.top_key  = stk_keys[stk_count - 1];
      res.top_data = stk_data[stk_count - 1];
    end
    res.entry_count = CNT_W'(stk_count);
    res.is_empty    = (stk_count == 0);
    return res;
  endfunction

  task automatic flag_field(string name, logic [31:0] exp, logic [31:0] got);
    if (got !== exp) begin
      if (error_cnt < REPORT_MAX)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, got);
      error_cnt++;
    end
  endtask

  task automatic check_result(stack_res_t exp, stack_res_t got);
    flag_field("status", 32'(exp.status), 32'(got.status));
    flag_field("popped_key", exp.popped_key, got.popped_key);
    flag_field("popped_data", exp.popped_data, got.popped_data);
    flag_field("top_key", exp.top_key, got.top_key);
    flag_field("top_data", exp.top_data, got.top_data);
    flag_field("entry_count", 32'(exp.entry_count), 32'(got.entry_count));
    flag_field("is_empty", 32'(exp.is_empty), 32'(got.is_empty));
  endtask

  task automatic add_req(kind_t kind, logic [31:0] key, logic [31:0] data);
    stack_req_t req;
    req.kind = kind;
    req.key  = key;
    req.data = data;
    pending_reqs.push_back(req);
  endtask

  // Build the request list, run reset, then wait for the drain
  initial begin
    logic [31:0] key_pool[KEY_POOL_N];
    int          queued;
    int          seg_len;
    int          push_pct;
    logic [31:0] key;
    bit          is_push;

    // underflow on an empty stack, extreme keys and data
    add_req(KIND_POP, 32'h0, 32'h0);
    add_req(KIND_PUSH, 32'h8000_0000, 32'h7fff_ffff);
    add_req(KIND_PUSH, 32'h7fff_ffff, 32'h8000_0000);
    // duplicate of the bottom entry is refused
    add_req(KIND_PUSH, 32'h8000_0000, 32'h1234_5678);
    add_req(KIND_PUSH, 32'h0, 32'h0);
    add_req(KIND_PUSH, 32'hffff_ffff, 32'hffff_ffff);
    add_req(KIND_POP, 32'hffff_ffff, 32'hffff_ffff);
    // fill to the top
    for (int i = 0; i < STACK_DEPTH - 3; i++)
      add_req(KIND_PUSH, 32'h100 + i, ~(32'h100 + i));
    // new key into a full stack overflows, a held key still reports duplicate
    add_req(KIND_PUSH, 32'h5555_5555, 32'haaaa_aaaa);
    add_req(KIND_PUSH, 32'h7fff_ffff, 32'h0);

    // small key pool so duplicates stay common
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < KEY_POOL_N; i++) key_pool[i] = $urandom;

    // random segments that lean toward filling, mixing or draining
    queued = 0;
    while (queued < RANDOM_REQS) begin
      seg_len = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0: begin
          push_pct = 85;
        end
        1: begin
          push_pct = 50;
        end
        default: begin
          push_pct = 20;
        end
      endcase
      for (int j = 0; j < seg_len; j++) begin
        is_push = ($urandom_range(0, 99) < push_pct);
        key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, KEY_POOL_N - 1)]
                                         : $urandom;
        add_req(is_push ? KIND_PUSH : KIND_POP, key, $urandom);
      end
      queued += seg_len;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    // every accepted request must have produced its result
    if (expected_results.size() != 0) begin
      if (error_cnt < REPORT_MAX)
        $display("%0t: missing results, expected %0d more, got none",
                 $time, expected_results.size());
      error_cnt++;
    end

    if (error_cnt == 0) begin
      $display("lifo_stack_unique_keys_test: done, clean");
    end else begin
      $display("lifo_stack_unique_keys_test: done, errors");
    end
    $finish;
  end

  // Send requests with a random gap after each
  always @(posedge clk) begin
    stack_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait = 0;
    end else if (!s_tvalid || s_tready) begin
      if (tx_wait != 0) begin
        tx_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {req.data, req.key};
        s_tuser  <= req.kind;
        if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
        tx_wait = tx_steady ? 0 : $urandom_range(0, 7);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall results at random, and hold off entirely during the long hold
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
        rx_wait = rx_steady ? 0 : $urandom_range(0, 7);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // Long receiver hold so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each result against the oldest expectation, then predict new requests
  always @(posedge clk) begin
    stack_res_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.status      = status_t'(m_tuser);
        got.popped_key  = m_tdata[31:0];
        got.popped_data = m_tdata[63:32];
        got.top_key     = m_tdata[95:64];
        got.top_data    = m_tdata[127:96];
        got.entry_count = m_tdata[128 +: CNT_W];
        got.is_empty    = m_tdata[128 + CNT_W];
        if (expected_results.size() == 0) begin
          if (error_cnt < REPORT_MAX)
            $display("%0t: result with none expected, expected nothing, got %h / %h",
                     $time, m_tuser, m_tdata);
          error_cnt++;
        end else begin
          check_result(expected_results.pop_front(), got);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_stack_request({kind_t'(s_tuser), s_tdata[31:0],
                                                        s_tdata[63:32]}));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("lifo_stack_unique_keys_test: done, errors");
      $finish;
    end
  end

endmodule

// ===== lifo_stack_unique_keys.f =====
design/lsuk_pkg.sv
design/lsuk_ram.sv
design/lifo_stack_unique_keys.sv
tb/sv/lifo_stack_unique_keys_test.sv
